// File: rtl/abrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrr_pkg
// Shared types, constants and helpers of the batch retention ring.
// ----------------------------------------------------------------------------
package abrr_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int BATCH_BYTES_DEF = 512;
    localparam int REPLY_BYTES_DEF = 2048;

    localparam int SEQ_W        = 32;
    localparam int SEAL_RESERVE = 9;
    localparam int OPEN_BYTES   = 4;
    localparam int REPLY_BASE   = 23;
    localparam int NAME_LEN_RST = 8;

    typedef enum logic [1:0] {
        ST_EMPTY  = 2'd0,
        ST_ACTIVE = 2'd1,
        ST_SEALED = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        KIND_APPEND  = 2'd0,
        KIND_BATCH   = 2'd1,
        KIND_SUMMARY = 2'd2
    } result_kind_t;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_POLL   = 1'b1;

    typedef struct packed {
        logic zero;
        logic neg;
    } cmp_res_t;

    // encoded length of an unsigned integer head
    function automatic logic [2:0] head_bytes(input logic [SEQ_W-1:0] v);
        logic [2:0] n;
        if (v < 32'd24)         n = 3'd1;
        else if (v < 32'd256)   n = 3'd2;
        else if (v < 32'd65536) n = 3'd3;
        else                    n = 3'd5;
        return n;
    endfunction

endpackage

// File: rtl/abrr_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrr_cmp
// Shared serial-number subtract and compare unit.
// ----------------------------------------------------------------------------
module abrr_cmp (
    input  logic [abrr_pkg::SEQ_W-1:0] op_a,
    input  logic [abrr_pkg::SEQ_W-1:0] op_b,
    output abrr_pkg::cmp_res_t         res
);
    logic [abrr_pkg::SEQ_W-1:0] d;

    assign d        = op_a - op_b;
    assign res.zero = (d == '0);
    assign res.neg  = d[abrr_pkg::SEQ_W-1];

endmodule

// File: rtl/acked_batch_retention_ring_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acked_batch_retention_ring_core
// Ring of batch slots with append, seal, evict, ack retirement and polling.
// ----------------------------------------------------------------------------
// An append, once accepted, takes a slot, checks the fit, adds and reports the
// message; a seal is followed by a slot search (empty scan, oldest-sealed scan, evict).
// A poll runs a retirement pass over all slots and one seal check, then a scan
// per selected batch and a closing search and summary, all through one shared
// serial compare unit.
// One word at a time; output stalls add cycles; the input is not ready until
// the last result is issued.
// aresetn (synchronous) empties all slots and sets the next sequence to one.
module acked_batch_retention_ring_core #(
    parameter int SLOTS       = abrr_pkg::SLOTS_DEF,
    parameter int BATCH_BYTES = abrr_pkg::BATCH_BYTES_DEF,
    parameter int REPLY_BYTES = abrr_pkg::REPLY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,      // name_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // msg_len, ack_seq, batch_cap
    input  logic        s_tuser,       // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // slot_index, batch_seq, batch_len, pending,
                                       // buffering, sealed, evicted, zero fill
    output logic [1:0]  m_tuser,       // result_kind
    output logic        m_tlast
);
    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int LW   = $clog2(BATCH_BYTES + 1);
    localparam int SUMW = $clog2(BATCH_BYTES + 512) + 1;
    localparam int UW   = $clog2(REPLY_BYTES + BATCH_BYTES + 1) + 1;
    localparam int SW   = abrr_pkg::SEQ_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DROP, S_TAKE, S_FINDE, S_FINDO, S_EVICT, S_FIT, S_ADD, S_AOUT,
        S_RET, S_PSEAL, S_SCAN0, S_SCAN1, S_PICK, S_EMIT, S_SUM
    } state_t;

    state_t                state_reg;
    abrr_pkg::slot_state_t status_reg [SLOTS];
    logic [LW-1:0]         len_reg    [SLOTS];
    logic [7:0]            cnt_reg    [SLOTS];
    logic [SW-1:0]         seq_reg    [SLOTS];
    logic [SW-1:0]         seq_ctr_reg;
    logic [5:0]            name_len_reg;
    logic                  act_valid_reg;
    logic [IW-1:0]         act_idx_reg;
    logic [CW-1:0]         n_sealed_reg;

    logic [7:0]            mlen_reg;
    logic [SW-1:0]         ack_reg;
    logic [CW-1:0]         cap_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         a_reg;
    logic [IW-1:0]         best_reg;
    logic [SW-1:0]         best_seq_reg;
    logic                  found_reg;
    logic                  second_reg;
    logic                  sealed_reg;
    logic                  ev_reg;
    logic [SW-1:0]         sseq_reg;
    logic [SW-1:0]         cursor_reg;
    logic [CW-1:0]         nsel_reg;
    logic [UW-1:0]         used_reg;

    logic                  m_valid_reg;
    logic [63:0]           m_data_reg;
    logic [1:0]            m_user_reg;
    logic                  m_last_reg;

    logic                  out_free;
    logic                  emit_now;
    logic [SW-1:0]         op_b;
    abrr_pkg::cmp_res_t    cmp;
    logic [7:0]            act_cnt;
    logic [7:0]            maxb;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit_now  = out_free && (state_reg == S_DROP || state_reg == S_AOUT ||
                                    state_reg == S_EMIT || state_reg == S_SUM);
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign m_tlast   = m_last_reg;
    assign act_cnt   = act_valid_reg ? cnt_reg[act_idx_reg] : 8'd0;
    assign maxb      = s_tdata[47:40];

    always_comb begin
        unique case (state_reg)
            S_RET:   op_b = ack_reg;
            S_SCAN0: op_b = cursor_reg;
            default: op_b = best_seq_reg;
        endcase
    end

    abrr_cmp u_cmp (
        .op_a (seq_reg[idx_reg]),
        .op_b (op_b),
        .res  (cmp)
    );

    function automatic logic [63:0] pack_out(
        input logic [IW-1:0] slot, input logic [SW-1:0] seq, input logic [LW-1:0] len,
        input logic [CW-1:0] pend, input logic [7:0] buff, input logic sl, input logic ev);
        logic [63:0] w;
        w        = '0;
        w[2:0]   = 3'(slot);
        w[34:3]  = seq;
        w[44:35] = 10'(len);
        w[48:45] = 4'(pend);
        w[56:49] = buff;
        w[57]    = sl;
        w[58]    = ev;
        return w;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < SLOTS; i++) status_reg[i] <= abrr_pkg::ST_EMPTY;
            seq_ctr_reg   <= SW'(1);
            name_len_reg  <= 6'(abrr_pkg::NAME_LEN_RST);
            act_valid_reg <= 1'b0;
            act_idx_reg   <= '0;
            n_sealed_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) name_len_reg <= cfg_data;
            if (m_tready && !emit_now) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        mlen_reg   <= s_tdata[7:0];
                        ack_reg    <= s_tdata[39:8];
                        cap_reg    <= (maxb >= 8'd1 && maxb <= 8'(SLOTS)) ?
                                      CW'(maxb) : CW'(SLOTS);
                        sealed_reg <= 1'b0;
                        ev_reg     <= 1'b0;
                        second_reg <= 1'b0;
                        sseq_reg   <= '0;
                        idx_reg    <= '0;
                        if (s_tuser == abrr_pkg::REQ_APPEND) begin
                            if (SUMW'(s_tdata[7:0]) + SUMW'(2 + abrr_pkg::SEAL_RESERVE
                                + abrr_pkg::OPEN_BYTES) > SUMW'(BATCH_BYTES))
                                state_reg <= S_DROP;
                            else
                                state_reg <= S_TAKE;
                        end else begin
                            state_reg <= S_RET;
                        end
                    end
                end
                S_DROP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= abrr_pkg::KIND_APPEND;
                        m_last_reg  <= 1'b1;
                        m_data_reg  <= pack_out('0, '0, '0, n_sealed_reg, act_cnt,
                                                1'b0, 1'b0);
                        state_reg   <= S_IDLE;
                    end
                end
                S_TAKE: begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    if (act_valid_reg) begin
                        a_reg     <= act_idx_reg;
                        state_reg <= second_reg ? S_ADD : S_FIT;
                    end else begin
                        state_reg <= S_FINDE;
                    end
                end
                S_FINDE: begin
                    if (status_reg[idx_reg] == abrr_pkg::ST_EMPTY) begin
                        status_reg[idx_reg] <= abrr_pkg::ST_ACTIVE;
                        len_reg[idx_reg]    <= LW'(abrr_pkg::OPEN_BYTES);
                        cnt_reg[idx_reg]    <= '0;
                        act_valid_reg       <= 1'b1;
                        act_idx_reg         <= idx_reg;
                        a_reg               <= idx_reg;
                        state_reg           <= second_reg ? S_ADD : S_FIT;
                    end else if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= S_FINDO;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FINDO: begin
                    if (status_reg[idx_reg] == abrr_pkg::ST_SEALED &&
                        (!found_reg || cmp.neg)) begin
                        found_reg    <= 1'b1;
                        best_reg     <= idx_reg;
                        best_seq_reg <= seq_reg[idx_reg];
                    end
                    if (idx_reg == LAST_IDX) state_reg <= S_EVICT;
                    else idx_reg <= idx_reg + 1'b1;
                end
                S_EVICT: begin
                    a_reg         <= found_reg ? best_reg : '0;
                    status_reg[found_reg ? best_reg : '0] <= abrr_pkg::ST_ACTIVE;
                    len_reg[found_reg ? best_reg : '0]    <= LW'(abrr_pkg::OPEN_BYTES);
                    cnt_reg[found_reg ? best_reg : '0]    <= '0;
                    act_valid_reg <= 1'b1;
                    act_idx_reg   <= found_reg ? best_reg : '0;
                    ev_reg        <= 1'b1;
                    if (found_reg) n_sealed_reg <= n_sealed_reg - 1'b1;
                    state_reg     <= second_reg ? S_ADD : S_FIT;
                end
                S_FIT: begin
                    if (SUMW'(mlen_reg) + SUMW'(len_reg[a_reg]) +
                        SUMW'(2 + abrr_pkg::SEAL_RESERVE) > SUMW'(BATCH_BYTES)) begin
                        seq_reg[a_reg]    <= seq_ctr_reg;
                        len_reg[a_reg]    <= len_reg[a_reg] + LW'(4)
                                             + LW'(abrr_pkg::head_bytes(seq_ctr_reg));
                        status_reg[a_reg] <= abrr_pkg::ST_SEALED;
                        n_sealed_reg      <= n_sealed_reg + 1'b1;
                        act_valid_reg     <= 1'b0;
                        sseq_reg          <= seq_ctr_reg;
                        seq_ctr_reg       <= seq_ctr_reg + 1'b1;
                        sealed_reg        <= 1'b1;
                        second_reg        <= 1'b1;
                        state_reg         <= S_TAKE;
                    end else begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: begin
                    len_reg[a_reg] <= len_reg[a_reg] + LW'(mlen_reg) + LW'(2);
                    if (cnt_reg[a_reg] != 8'hFF) cnt_reg[a_reg] <= cnt_reg[a_reg] + 8'd1;
                    state_reg <= S_AOUT;
                end
                S_AOUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= abrr_pkg::KIND_APPEND;
                        m_last_reg  <= 1'b1;
                        m_data_reg  <= pack_out(a_reg, sseq_reg, len_reg[a_reg],
                                                n_sealed_reg, cnt_reg[a_reg],
                                                sealed_reg, ev_reg);
                        state_reg   <= S_IDLE;
                    end
                end
                S_RET: begin
                    if (status_reg[idx_reg] == abrr_pkg::ST_SEALED &&
                        (cmp.zero || cmp.neg)) begin
                        status_reg[idx_reg] <= abrr_pkg::ST_EMPTY;
                        n_sealed_reg        <= n_sealed_reg - 1'b1;
                    end
                    if (idx_reg == LAST_IDX) state_reg <= S_PSEAL;
                    else idx_reg <= idx_reg + 1'b1;
                end
                S_PSEAL: begin
                    if (n_sealed_reg == '0 && act_valid_reg &&
                        cnt_reg[act_idx_reg] != 8'd0) begin
                        seq_reg[act_idx_reg]    <= seq_ctr_reg;
                        len_reg[act_idx_reg]    <= len_reg[act_idx_reg] + LW'(4)
                                                   + LW'(abrr_pkg::head_bytes(seq_ctr_reg));
                        status_reg[act_idx_reg] <= abrr_pkg::ST_SEALED;
                        n_sealed_reg            <= n_sealed_reg + 1'b1;
                        act_valid_reg           <= 1'b0;
                        seq_ctr_reg             <= seq_ctr_reg + 1'b1;
                        sealed_reg              <= 1'b1;
                    end
                    idx_reg    <= '0;
                    found_reg  <= 1'b0;
                    cursor_reg <= ack_reg;
                    nsel_reg   <= '0;
                    used_reg   <= UW'(abrr_pkg::REPLY_BASE) + UW'(name_len_reg);
                    state_reg  <= S_SCAN0;
                end
                S_SCAN0: begin
                    if (status_reg[idx_reg] == abrr_pkg::ST_SEALED && !cmp.zero &&
                        !cmp.neg && found_reg) begin
                        state_reg <= S_SCAN1;
                    end else begin
                        if (status_reg[idx_reg] == abrr_pkg::ST_SEALED && !cmp.zero &&
                            !cmp.neg) begin
                            found_reg    <= 1'b1;
                            best_reg     <= idx_reg;
                            best_seq_reg <= seq_reg[idx_reg];
                        end
                        if (idx_reg == LAST_IDX) state_reg <= S_PICK;
                        else idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCAN1: begin
                    if (cmp.neg) begin
                        best_reg     <= idx_reg;
                        best_seq_reg <= seq_reg[idx_reg];
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= S_PICK;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN0;
                    end
                end
                S_PICK: begin
                    if (nsel_reg >= cap_reg || !found_reg ||
                        used_reg + UW'(len_reg[best_reg]) > UW'(REPLY_BYTES))
                        state_reg <= S_SUM;
                    else
                        state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= abrr_pkg::KIND_BATCH;
                        m_last_reg  <= 1'b0;
                        m_data_reg  <= pack_out(best_reg, best_seq_reg, len_reg[best_reg],
                                                '0, '0, 1'b0, 1'b0);
                        used_reg    <= used_reg + UW'(len_reg[best_reg]);
                        cursor_reg  <= best_seq_reg;
                        nsel_reg    <= nsel_reg + 1'b1;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        state_reg   <= S_SCAN0;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= abrr_pkg::KIND_SUMMARY;
                        m_last_reg  <= 1'b1;
                        m_data_reg  <= pack_out('0, '0, '0, n_sealed_reg - nsel_reg,
                                                act_cnt, sealed_reg, 1'b0);
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_sealed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_sealed_reg <= CW'(SLOTS))
        else $error("sealed count exceeds slot count");

    a_active_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        act_valid_reg |-> status_reg[act_idx_reg] == abrr_pkg::ST_ACTIVE)
        else $error("active index does not point at an active slot");

    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && m_valid_reg) |-> m_last_reg)
        else $error("idle with a non-final result pending");

    a_nsel_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN0 || state_reg == S_PICK || state_reg == S_SUM)
        |-> nsel_reg <= n_sealed_reg)
        else $error("more batches selected than sealed");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the acked batch retention ring core. A short directed run
// exercises extreme message sizes, polls on an empty ring, caps of zero, one
// and above the slot count, and eviction of sealed batches. A random run then
// mixes append bursts with acknowledging polls and noisy acks. All results are
// compared field by field against a predictor of the slot ring kept in a
// small scoreboard class, under random stalls on both sides, one long output
// hold-off and several name length settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NSLOT = 8;
    localparam int BATCH_MAX = 512;
    localparam int REPLY_MAX = 2048;

    typedef struct {
        abrr_pkg::result_kind_t kind;
        logic [2:0]   slot;
        logic [31:0]  seq;
        logic [9:0]   len;
        logic [3:0]   pend;
        logic [7:0]   buffering;
        logic         sealed;
        logic         evicted;
        logic         last;
    } ring_result_t;

    int errors = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    class ring_scoreboard;
        abrr_pkg::slot_state_t state_q[NSLOT];
        logic [9:0]   blen[NSLOT];
        logic [7:0]   mcount[NSLOT];
        logic [31:0]  bseq[NSLOT];
        logic [31:0]  seq_ctr;
        logic [5:0]   name_len;
        ring_result_t pending_results[$];

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                state_q[i] = abrr_pkg::ST_EMPTY;
                blen[i] = '0;
                mcount[i] = '0;
                bseq[i] = '0;
            end
            seq_ctr = 32'd1;
            name_len = 6'(abrr_pkg::NAME_LEN_RST);
        endfunction

        function bit older(input logic [31:0] a, input logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return d[31];
        endfunction

        function int head_len(input logic [31:0] v);
            if (v < 24) return 1;
            if (v < 256) return 2;
            if (v < 65536) return 3;
            return 5;
        endfunction

        function logic [31:0] seal(input int i);
            logic [31:0] s;
            s = seq_ctr;
            seq_ctr = seq_ctr + 32'd1;
            bseq[i] = s;
            blen[i] = 10'(blen[i] + 4 + head_len(s));
            state_q[i] = abrr_pkg::ST_SEALED;
            return s;
        endfunction

        function int sealed_total();
            int n;
            n = 0;
            foreach (state_q[i]) if (state_q[i] == abrr_pkg::ST_SEALED) n++;
            return n;
        endfunction

        function logic [7:0] open_count();
            foreach (state_q[i]) if (state_q[i] == abrr_pkg::ST_ACTIVE) return mcount[i];
            return '0;
        endfunction

        function int grab_slot(inout bit ev);
            int v;
            v = -1;
            foreach (state_q[i]) if (state_q[i] == abrr_pkg::ST_ACTIVE) return i;
            foreach (state_q[i]) if (state_q[i] == abrr_pkg::ST_EMPTY && v < 0) v = i;
            if (v < 0) begin
                foreach (state_q[i])
                    if (state_q[i] == abrr_pkg::ST_SEALED &&
                        (v < 0 || older(bseq[i], bseq[v]))) v = i;
                if (v < 0) v = 0;
                ev = 1;
            end
            state_q[v] = abrr_pkg::ST_ACTIVE;
            blen[v] = 10'(abrr_pkg::OPEN_BYTES);
            mcount[v] = '0;
            return v;
        endfunction

        function int next_above(input logic [31:0] cur);
            int b;
            logic [31:0] d;
            b = -1;
            foreach (state_q[i]) begin
                d = bseq[i] - cur;
                if (state_q[i] == abrr_pkg::ST_SEALED && d != 0 && !d[31])
                    if (b < 0 || older(bseq[i], bseq[b])) b = i;
            end
            return b;
        endfunction

        function void push(input abrr_pkg::result_kind_t k, input int slot,
                           input logic [31:0] s, input int l, input int p, input int bf,
                           input bit sl, input bit ev, input bit lst);
            ring_result_t r;
            r.kind = k; r.slot = 3'(slot); r.seq = s; r.len = 10'(l); r.pend = 4'(p);
            r.buffering = 8'(bf); r.sealed = sl; r.evicted = ev; r.last = lst;
            pending_results.push_back(r);
        endfunction

        function void note_input(input logic req, input logic [7:0] mlen,
                                 input logic [31:0] ack, input logic [7:0] maxb);
            bit ev, sl;
            int a, cap, used, nsel, b;
            logic [31:0] sseq, cur, d;
            ev = 0; sl = 0; sseq = '0;
            if (req == abrr_pkg::REQ_APPEND) begin
                if (2 + mlen + abrr_pkg::SEAL_RESERVE + abrr_pkg::OPEN_BYTES > BATCH_MAX)
                begin
                    push(abrr_pkg::KIND_APPEND, 0, 0, 0, sealed_total(), open_count(),
                         0, 0, 1);
                    return;
                end
                a = grab_slot(ev);
                if (2 + mlen + abrr_pkg::SEAL_RESERVE + blen[a] > BATCH_MAX) begin
                    sseq = seal(a);
                    sl = 1;
                    a = grab_slot(ev);
                end
                blen[a] = 10'(blen[a] + mlen + 2);
                if (mcount[a] < 255) mcount[a]++;
                push(abrr_pkg::KIND_APPEND, a, sseq, blen[a], sealed_total(), mcount[a],
                     sl, ev, 1);
                return;
            end
            foreach (state_q[i]) begin
                d = bseq[i] - ack;
                if (state_q[i] == abrr_pkg::ST_SEALED && (d == 0 || d[31]))
                    state_q[i] = abrr_pkg::ST_EMPTY;
            end
            if (sealed_total() == 0)
                foreach (state_q[i])
                    if (!sl && state_q[i] == abrr_pkg::ST_ACTIVE && mcount[i] > 0) begin
                        void'(seal(i));
                        sl = 1;
                    end
            cap = (maxb >= 1 && maxb <= NSLOT) ? maxb : NSLOT;
            used = abrr_pkg::REPLY_BASE + name_len;
            cur = ack;
            nsel = 0;
            while (nsel < cap) begin
                b = next_above(cur);
                if (b < 0 || used + blen[b] > REPLY_MAX) break;
                push(abrr_pkg::KIND_BATCH, b, bseq[b], blen[b], 0, 0, 0, 0, 0);
                used += blen[b];
                cur = bseq[b];
                nsel++;
            end
            push(abrr_pkg::KIND_SUMMARY, 0, 0, 0, sealed_total() - nsel, open_count(),
                 sl, 0, 1);
        endfunction

        task check_result(input logic [63:0] data, input logic [1:0] kind,
                          input logic lst);
            ring_result_t e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected word %h kind %0d", data, kind));
                return;
            end
            e = pending_results.pop_front();
            if (kind != e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
            if (data[2:0] != e.slot) report($sformatf("slot %0d, want %0d", data[2:0], e.slot));
            if (data[34:3] != e.seq) report($sformatf("seq %0d, want %0d", data[34:3], e.seq));
            if (data[44:35] != e.len) report($sformatf("len %0d, want %0d", data[44:35], e.len));
            if (data[48:45] != e.pend)
                report($sformatf("pending %0d, want %0d", data[48:45], e.pend));
            if (data[56:49] != e.buffering)
                report($sformatf("buffering %0d, want %0d", data[56:49], e.buffering));
            if (data[57] != e.sealed) report($sformatf("sealed %0b, want %0b", data[57], e.sealed));
            if (data[58] != e.evicted)
                report($sformatf("evicted %0b, want %0b", data[58], e.evicted));
            if (data[63:59] != 0) report("nonzero fill bits");
            if (lst != e.last) report($sformatf("last %0b, want %0b", lst, e.last));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    ring_scoreboard sb = new();
    bit calm = 0;
    bit held = 0;
    int hold_left = 0;
    int sent = 0;

    acked_batch_retention_ring_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stalls plus an optional long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 0;
            hold_left--;
        end else begin
            m_tready = calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_word(input logic req, input logic [7:0] mlen,
                             input logic [31:0] ack, input logic [7:0] maxb);
        while (!calm && $urandom_range(99) < 9) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = req;
        s_tdata = {maxb, ack, mlen};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(req, mlen, ack, maxb);
        sent++;
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic append(input logic [7:0] mlen);
        send_word(abrr_pkg::REQ_APPEND, mlen, $urandom, 8'($urandom));
    endtask

    task automatic poll(input logic [31:0] ack, input logic [7:0] maxb);
        send_word(abrr_pkg::REQ_POLL, 8'($urandom), ack, maxb);
    endtask

    task automatic write_name_len(input logic [5:0] v);
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_valid = 1;
        cfg_data = v;
        do @(posedge aclk); while (!cfg_ready);
        sb.name_len = v;
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    function automatic logic [31:0] pick_ack();
        int r;
        r = $urandom_range(99);
        if (r < 60) return sb.seq_ctr - 1 - $urandom_range(0, 3);
        if (r < 80) return $urandom;
        return sb.seq_ctr - 1 - $urandom_range(4, 12);
    endfunction

    initial begin
        int n, wait_cycles;
        repeat (7) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        write_name_len(6'd63);
        poll(32'd0, 8'd0);
        append(8'd0);
        append(8'd255);
        append(8'd1);
        append(8'd128);
        poll(32'd0, 8'd1);
        poll(32'hFFFF_FFFF, 8'd255);
        for (int i = 0; i < 11; i++) append(8'd255);
        poll(32'd0, 8'd9);
        poll(32'd0, 8'd8);
        poll(sb.seq_ctr - 3, 8'd2);
        poll(32'h8000_0000, 8'd0);

        write_name_len(6'd0);
        while (sent < 210) begin
            if (sent > 60 && sent < 110) calm = 1;
            else calm = 0;
            if (!held && sent >= 150) begin
                hold_left = 400;
                held = 1;
            end
            n = $urandom_range(2, 40);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(99) < 5) append(8'($urandom));
                else if ($urandom_range(99) < 20) append(8'($urandom_range(100, 128)));
                else append(8'($urandom_range(1, 128)));
            end
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                poll(pick_ack(),
                     8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 10)));
            if (sent > 120 && sb.name_len == 0) write_name_len(6'($urandom_range(1, 62)));
            else if (sent > 200 && sb.name_len != 63 &&
                     sb.name_len != abrr_pkg::NAME_LEN_RST)
                write_name_len(6'd63);
        end
        calm = 0;

        wait_cycles = 0;
        while (sb.pending_results.size() != 0 && wait_cycles < 20000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        if (sb.pending_results.size() != 0) report("results missing at end");
        repeat (200) @(negedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: acked_batch_retention_ring_core.f
rtl/abrr_pkg.sv
rtl/abrr_cmp.sv
rtl/acked_batch_retention_ring_core.sv
test/tb_top.sv
